// ===== sv/ffsl_pkg.sv =====
// Package for the frame format survey and lock block: widths, codes, slot types.
`default_nettype none
package ffsl_pkg;

	localparam int SURVEY_SLOTS = 4;
	localparam int LEN_W        = 10;
	localparam int FMT_W        = 4;
	localparam int TALLY_W      = 10;
	localparam int CNT_W        = 10;
	localparam int MISMATCH_W   = 32;
	localparam int CFG_W        = 10;
	localparam int CFG_IDX_W    = 1;
	localparam int QUARTER_SHIFT = 2;

	localparam logic [CFG_W-1:0] SURVEY_LENGTH_RST = 10'd64;
	localparam logic [CFG_W-1:0] SHARE_FLOOR_RST   = 10'd4;

	typedef enum logic [1:0] {
		VERDICT_SURVEY   = 2'd0,
		VERDICT_ACCEPT   = 2'd1,
		VERDICT_MISMATCH = 2'd2
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SURVEY_LENGTH = 1'b0,
		CFG_SHARE_FLOOR   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [FMT_W-1:0] format;
	} pair_t;

	// tally of zero marks a free slot
	typedef struct packed {
		logic [LEN_W-1:0]   length;
		logic [FMT_W-1:0]   format;
		logic [TALLY_W-1:0] tally;
	} slot_t;

	typedef slot_t [SURVEY_SLOTS-1:0] slot_bank_t;

endpackage
`default_nettype wire

// ===== sv/ffsl_in_if.sv =====
// Request channel carrying one frame descriptor.
`default_nettype none
interface ffsl_in_if
	import ffsl_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] frame_length;
	logic [FMT_W-1:0] frame_format;

	modport source (output valid, output frame_length, output frame_format, input ready);
	modport sink   (input valid, input frame_length, input frame_format, output ready);
endinterface
`default_nettype wire

// ===== sv/ffsl_out_if.sv =====
// Result channel carrying one verdict per frame.
`default_nettype none
interface ffsl_out_if
	import ffsl_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [1:0]            verdict;
	logic                  is_locked;
	logic [LEN_W-1:0]      chosen_length;
	logic [FMT_W-1:0]      chosen_format;
	logic [MISMATCH_W-1:0] mismatch_total;

	modport source (output valid, output verdict, output is_locked, output chosen_length,
		output chosen_format, output mismatch_total, input ready);
	modport sink   (input valid, input verdict, input is_locked, input chosen_length,
		input chosen_format, input mismatch_total, output ready);
endinterface
`default_nettype wire

// ===== sv/ffsl_tally.sv =====
// Slot tally update: bumps the matching slot, else claims the lowest free one.
`default_nettype none
module ffsl_tally
	import ffsl_pkg::*;
(
	input  slot_bank_t slots,
	input  pair_t      frame,
	output slot_bank_t slots_next
);

	logic [SURVEY_SLOTS-1:0] used;
	logic [SURVEY_SLOTS-1:0] match;
	logic [SURVEY_SLOTS-1:0] sel;
	logic [SURVEY_SLOTS-1:0] hit_oh;

	always_comb begin
		for (int i = 0; i < SURVEY_SLOTS; i++) begin
			used[i]  = |slots[i].tally;
			match[i] = used[i] && slots[i].length == frame.length
				&& slots[i].format == frame.format;
		end
		sel    = (|match) ? match : ~used;
		// isolate lowest set bit
		hit_oh = sel & (~sel + SURVEY_SLOTS'(1));
		for (int i = 0; i < SURVEY_SLOTS; i++) begin
			slots_next[i] = slots[i];
			if (hit_oh[i]) begin
				slots_next[i].length = frame.length;
				slots_next[i].format = frame.format;
				slots_next[i].tally  = slots[i].tally + TALLY_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/ffsl_pick.sv =====
// Lock choice: longest recurring pair, else most common, else the current frame.
`default_nettype none
module ffsl_pick
	import ffsl_pkg::*;
(
	input  slot_bank_t       slots,
	input  logic [CNT_W-1:0] need,
	input  pair_t            frame,
	output pair_t            choice
);

	logic [SURVEY_SLOTS-1:0] used;
	logic [SURVEY_SLOTS-1:0] cand;
	logic [SURVEY_SLOTS-1:0] win_len;
	logic [SURVEY_SLOTS-1:0] win_cnt;
	pair_t                   pick_len;
	pair_t                   pick_cnt;

	always_comb begin
		for (int i = 0; i < SURVEY_SLOTS; i++) begin
			used[i] = |slots[i].tally;
			cand[i] = used[i] && (CNT_W'(slots[i].tally) >= need);
		end
		// all-pairs knockout; lower slot wins a tie
		for (int i = 0; i < SURVEY_SLOTS; i++) begin
			win_len[i] = cand[i];
			win_cnt[i] = used[i];
			for (int j = 0; j < SURVEY_SLOTS; j++) begin
				if (j != i) begin
					if (cand[j] && (slots[j].length > slots[i].length
						|| (slots[j].length == slots[i].length && j < i)))
						win_len[i] = 1'b0;
					if (used[j] && (slots[j].tally > slots[i].tally
						|| (slots[j].tally == slots[i].tally && j < i)))
						win_cnt[i] = 1'b0;
				end
			end
		end
		pick_len = '0;
		pick_cnt = '0;
		for (int i = 0; i < SURVEY_SLOTS; i++) begin
			if (win_len[i])
				pick_len = pick_len | pair_t'({slots[i].length, slots[i].format});
			if (win_cnt[i])
				pick_cnt = pick_cnt | pair_t'({slots[i].length, slots[i].format});
		end
		priority if (|cand)
			choice = pick_len;
		else if (|used)
			choice = pick_cnt;
		else
			choice = frame;
	end

endmodule
`default_nettype wire

// ===== sv/frame_format_survey_lock.sv =====
// Frame format survey and lock: top level with input stage, state and result register.
// The input stage registers each accepted frame; its verdict is then registered in the result stage.
// Throughput: one frame descriptor per cycle while the result side accepts; the survey, lock choice
//   and verdict are settled combinationally between input and result registers.
// Reset (arst_n low): clears slots, survey count, lock and mismatch counter,
//   and returns survey_length to 64 and share_floor to 4; no clearing pass.
`default_nettype none
module frame_format_survey_lock
	import ffsl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	ffsl_in_if.sink                   frames,
	ffsl_out_if.source                results
);

	// configuration
	logic [CFG_W-1:0] survey_length_q;
	logic [CFG_W-1:0] share_floor_q;

	// input stage
	logic  valid_s1;
	pair_t frame_s1;

	// session state
	slot_bank_t            slots_q;
	logic [CNT_W-1:0]      surveyed_q;
	logic                  lock_q;
	pair_t                 lock_pair_q;
	logic [MISMATCH_W-1:0] mismatch_q;

	// result stage
	logic                  valid_s2;
	verdict_t              verdict_s2;
	logic                  locked_s2;
	pair_t                 chosen_s2;
	logic [MISMATCH_W-1:0] mismatch_s2;

	logic                  advance;
	slot_bank_t            slots_tallied;
	logic [CNT_W-1:0]      surveyed_next;
	logic [CNT_W-1:0]      quarter;
	logic [CNT_W-1:0]      need;
	logic                  decide;
	pair_t                 pick_pair;
	pair_t                 lock_pair_d;
	logic                  locked_now;
	verdict_t              verdict_d;
	logic [MISMATCH_W-1:0] mismatch_d;

	assign advance      = valid_s1 && (!valid_s2 || results.ready);
	assign frames.ready = !valid_s1 || advance;

	ffsl_tally u_tally (
		.slots      (slots_q),
		.frame      (frame_s1),
		.slots_next (slots_tallied)
	);

	ffsl_pick u_pick (
		.slots  (slots_tallied),
		.need   (need),
		.frame  (frame_s1),
		.choice (pick_pair)
	);

	always_comb begin
		surveyed_next = surveyed_q + CNT_W'(1);
		quarter       = surveyed_next >> QUARTER_SHIFT;
		need          = (quarter < CNT_W'(share_floor_q)) ? CNT_W'(share_floor_q) : quarter;
		decide        = !lock_q && (surveyed_next >= CNT_W'(survey_length_q));
		lock_pair_d   = lock_q ? lock_pair_q : pick_pair;
		locked_now    = lock_q || decide;
		verdict_d     = VERDICT_SURVEY;
		mismatch_d    = mismatch_q;
		if (locked_now) begin
			if (frame_s1 == lock_pair_d) begin
				verdict_d = VERDICT_ACCEPT;
			end else begin
				verdict_d  = VERDICT_MISMATCH;
				mismatch_d = mismatch_q + MISMATCH_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			survey_length_q <= SURVEY_LENGTH_RST;
			share_floor_q   <= SHARE_FLOOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SURVEY_LENGTH: survey_length_q <= cfg_data;
				CFG_SHARE_FLOOR:   share_floor_q   <= cfg_data;
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frames.ready) begin
			valid_s1 <= frames.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frames.valid && frames.ready) begin
			frame_s1.length <= frames.frame_length;
			frame_s1.format <= frames.frame_format;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q     <= '0;
			surveyed_q  <= '0;
			lock_q      <= 1'b0;
			lock_pair_q <= '0;
			mismatch_q  <= '0;
		end else if (advance) begin
			if (!lock_q) begin
				slots_q    <= slots_tallied;
				surveyed_q <= surveyed_next;
			end
			if (decide) begin
				lock_q      <= 1'b1;
				lock_pair_q <= pick_pair;
			end
			mismatch_q <= mismatch_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_s2  <= verdict_d;
			locked_s2   <= locked_now;
			chosen_s2   <= locked_now ? lock_pair_d : '0;
			mismatch_s2 <= mismatch_d;
		end
	end

	assign results.valid          = valid_s2;
	assign results.verdict        = verdict_s2;
	assign results.is_locked      = locked_s2;
	assign results.chosen_length  = chosen_s2.length;
	assign results.chosen_format  = chosen_s2.format;
	assign results.mismatch_total = mismatch_s2;

endmodule
`default_nettype wire

// ===== tb/ffsl_verdict_checker.sv =====
// Checker for the frame format survey and lock block: predicts each verdict and compares.
`timescale 1ns / 1ps
module ffsl_verdict_checker
	import ffsl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	ffsl_in_if                        frames,
	ffsl_out_if                       results,
	output int unsigned               errors,
	output int unsigned               pending,
	output int unsigned               checked,
	output logic                      locked,
	output pair_t                     locked_pair
);

	typedef struct packed {
		verdict_t              verdict;
		logic                  is_locked;
		pair_t                 chosen;
		logic [MISMATCH_W-1:0] mismatch_total;
	} frame_verdict_t;

	slot_bank_t            slots;
	logic [CNT_W-1:0]      surveyed;
	logic                  lock_on;
	pair_t                 lock_pair;
	logic [MISMATCH_W-1:0] rejects;
	logic [CFG_W-1:0]      survey_len;
	logic [CFG_W-1:0]      floor_tally;
	frame_verdict_t        verdicts_due[$];
	int unsigned           fail_tally = 0;
	int unsigned           checked_tally = 0;

	task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
		fail_tally++;
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// matching slot first, else lowest free slot; full bank drops the pair
	task automatic tally_pair(input pair_t p);
		int hit;
		hit = -1;
		for (int i = 0; i < SURVEY_SLOTS; i++) begin
			if (slots[i].tally != 0 && slots[i].length == p.length
					&& slots[i].format == p.format) begin
				hit = i;
				break;
			end
			if (slots[i].tally == 0 && hit < 0)
				hit = i;
		end
		if (hit >= 0) begin
			slots[hit].length = p.length;
			slots[hit].format = p.format;
			slots[hit].tally  = slots[hit].tally + 1'b1;
		end
	endtask

	function automatic pair_t pick_lock(input pair_t current);
		logic [TALLY_W-1:0] need;
		int pick;
		need = surveyed >> QUARTER_SHIFT;
		if (need < floor_tally)
			need = floor_tally;
		pick = -1;
		// longest recurring pair, ties to the lowest slot
		for (int i = 0; i < SURVEY_SLOTS; i++)
			if (slots[i].tally != 0 && slots[i].tally >= need
					&& (pick < 0 || slots[i].length > slots[pick].length))
				pick = i;
		// else the most common pair
		if (pick < 0)
			for (int i = 0; i < SURVEY_SLOTS; i++)
				if (slots[i].tally != 0 && (pick < 0 || slots[i].tally > slots[pick].tally))
					pick = i;
		if (pick < 0)
			return current;
		return '{length: slots[pick].length, format: slots[pick].format};
	endfunction

	task automatic judge_frame(input pair_t p, output frame_verdict_t v);
		v.verdict = VERDICT_SURVEY;
		if (!lock_on) begin
			tally_pair(p);
			surveyed = surveyed + 1'b1;
			if (surveyed >= survey_len) begin
				lock_pair = pick_lock(p);
				lock_on   = 1'b1;
			end
		end
		if (lock_on) begin
			if (p == lock_pair) begin
				v.verdict = VERDICT_ACCEPT;
			end else begin
				v.verdict = VERDICT_MISMATCH;
				rejects   = rejects + 1'b1;
			end
		end
		v.is_locked      = lock_on;
		v.chosen         = lock_on ? lock_pair : '0;
		v.mismatch_total = rejects;
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_verdict_t fresh;
		frame_verdict_t want;
		if (!arst_n) begin
			slots       = '0;
			surveyed    = '0;
			lock_on     = 1'b0;
			lock_pair   = '0;
			rejects     = '0;
			survey_len  = SURVEY_LENGTH_RST;
			floor_tally = SHARE_FLOOR_RST;
			verdicts_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_SURVEY_LENGTH: survey_len  = cfg_data;
					CFG_SHARE_FLOOR:   floor_tally = cfg_data;
					default: ;
				endcase
			end
			if (frames.valid && frames.ready) begin
				judge_frame('{length: frames.frame_length, format: frames.frame_format}, fresh);
				verdicts_due.push_back(fresh);
			end
			if (results.valid && results.ready) begin
				if (verdicts_due.size() == 0) begin
					flag("result with no frame waiting", results.verdict, 0);
				end else begin
					want = verdicts_due.pop_front();
					checked_tally++;
					if (results.verdict !== want.verdict)
						flag("verdict", results.verdict, want.verdict);
					if (results.is_locked !== want.is_locked)
						flag("is_locked", results.is_locked, want.is_locked);
					if (results.chosen_length !== want.chosen.length)
						flag("chosen_length", results.chosen_length, want.chosen.length);
					if (results.chosen_format !== want.chosen.format)
						flag("chosen_format", results.chosen_format, want.chosen.format);
					if (results.mismatch_total !== want.mismatch_total)
						flag("mismatch_total", results.mismatch_total, want.mismatch_total);
				end
			end
		end
		errors      <= fail_tally;
		pending     <= verdicts_due.size();
		checked     <= checked_tally;
		locked      <= lock_on;
		locked_pair <= lock_pair;
	end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, frame and result traffic, register writes and the verdict.
`timescale 1ns / 1ps
module tb_top;
	import ffsl_pkg::*;

	localparam int LIMIT_CYCLES   = 100000;
	localparam int IDLE_PCT       = 29;
	localparam int HOLD_START     = 200;
	localparam int HOLD_CYCLES    = 120;
	localparam int CALM_FROM      = 1400;
	localparam int CALM_TO        = 1800;
	localparam int SEND_CALM_FROM = 500;
	localparam int SEND_CALM_TO   = 650;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ffsl_in_if  frames();
	ffsl_out_if results();

	int unsigned errors;
	int unsigned pending;
	int unsigned checked;
	logic        locked;
	pair_t       locked_pair;

	int unsigned cycles = 0;
	int unsigned sent = 0;
	int unsigned floor_at_lock;
	logic        zero_survey;
	pair_t       pool[4];
	int unsigned weight[4];

	// first six fill the four slots; the odd pairs after them find no free slot
	pair_t directed[12] = '{
		'{10'd0, 4'd0}, '{10'd0, 4'd0}, '{10'd1023, 4'd15}, '{10'd1023, 4'd15},
		'{10'd0, 4'd15}, '{10'd1023, 4'd0}, '{10'd512, 4'd5}, '{10'd1, 4'd1},
		'{10'd0, 4'd0}, '{10'h155, 4'hA}, '{10'h2AA, 4'h5}, '{10'd1022, 4'd14}
	};

	frame_format_survey_lock dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frames    (frames),
		.results   (results)
	);

	ffsl_verdict_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.frames      (frames),
		.results     (results),
		.errors      (errors),
		.pending     (pending),
		.checked     (checked),
		.locked      (locked),
		.locked_pair (locked_pair)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: one long hold-off so the block backs up, one calm stretch
	initial begin : result_side
		int unsigned n;
		n = 0;
		results.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			n++;
			if (n >= HOLD_START && n < HOLD_START + HOLD_CYCLES)
				results.ready <= 1'b0;
			else if (n >= CALM_FROM && n < CALM_TO)
				results.ready <= 1'b1;
			else
				results.ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic pair_t random_pair();
		return '{length: 10'($urandom_range(1023)), format: 4'($urandom_range(15))};
	endfunction

	// survey: mostly the slot pairs at skewed weights; after lock: hits and near misses
	function automatic pair_t frame_pick();
		int unsigned total;
		int unsigned r;
		r = $urandom_range(99);
		if (locked) begin
			if (r < 50)
				return locked_pair;
			if (r < 60)
				return '{length: locked_pair.length, format: locked_pair.format + 4'd1};
			if (r < 70)
				return '{length: locked_pair.length + 10'd1, format: locked_pair.format};
			if (r >= 85)
				return random_pair();
		end else if (r < 20) begin
			return random_pair();
		end
		total = weight[0] + weight[1] + weight[2] + weight[3];
		r = $urandom_range(total - 1);
		for (int i = 0; i < 4; i++) begin
			if (r < weight[i])
				return pool[i];
			r -= weight[i];
		end
		return pool[0];
	endfunction

	task automatic send_frame(input pair_t p);
		if (!(sent >= SEND_CALM_FROM && sent < SEND_CALM_TO))
			while ($urandom_range(99) < IDLE_PCT) begin
				frames.valid <= 1'b0;
				@(posedge clk);
			end
		frames.valid        <= 1'b1;
		frames.frame_length <= p.length;
		frames.frame_format <= p.format;
		@(posedge clk);
		while (!frames.ready)
			@(posedge clk);
		sent++;
	endtask

	// stop offering and wait for every outstanding verdict
	task automatic settle();
		frames.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] survey, input logic [CFG_W-1:0] floor_v);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SURVEY_LENGTH;
		cfg_data  <= survey;
		@(posedge clk);
		cfg_index <= CFG_SHARE_FLOOR;
		cfg_data  <= floor_v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : stimulus
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= CFG_SURVEY_LENGTH;
		cfg_data            <= '0;
		frames.valid        <= 1'b0;
		frames.frame_length <= '0;
		frames.frame_format <= '0;
		pool[0] = '{10'd0, 4'd0};
		pool[1] = '{10'd1023, 4'd15};
		pool[2] = '{10'd0, 4'd15};
		pool[3] = '{10'd1023, 4'd0};
		for (int i = 0; i < 4; i++)
			weight[i] = $urandom_range(1, 10);
		case ($urandom_range(2))
			0:       floor_at_lock = 0;
			1:       floor_at_lock = 1023;
			default: floor_at_lock = $urandom_range(1, 200);
		endcase
		zero_survey = $urandom_range(1);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(10'd1023, 10'd0);
		foreach (directed[i])
			send_frame(directed[i]);
		settle();

		set_config(10'd1023, 10'd1023);
		repeat (300) send_frame(frame_pick());
		settle();

		// mid-survey write: either lock on the next frame or after 300 more
		set_config(zero_survey ? 10'd0 : 10'(sent + 300), 10'(floor_at_lock));
		repeat (400) send_frame(frame_pick());
		settle();

		// writes after lock must change nothing
		set_config(10'd0, 10'd0);
		repeat (150) send_frame(frame_pick());
		settle();
		set_config(10'd1, 10'd1023);
		repeat (190) send_frame(frame_pick());
		settle();
		repeat (4) @(posedge clk);

		$display("%0d frame descriptors sent, %0d verdicts checked; survey closed %s, floor %0d",
			sent, checked, zero_survey ? "by a zero survey length" : "at its length",
			floor_at_lock);
		$display("locked to length %0d format %0d, with a long result stall and drain pauses",
			locked_pair.length, locked_pair.format);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== frame_format_survey_lock.f =====
sv/ffsl_pkg.sv
sv/ffsl_in_if.sv
sv/ffsl_out_if.sv
sv/ffsl_tally.sv
sv/ffsl_pick.sv
sv/frame_format_survey_lock.sv
tb/ffsl_verdict_checker.sv
tb/tb_top.sv
